>>> sv/hcbad_pkg.sv
// Shared types and constants for the home computer bank address decoder.
// Used by hcbad_decode and home_computer_bank_address_decoder; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hcbad_pkg;

  // Request codes
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_JUMP  = 2'd2;

  // Environment codes
  localparam logic [1:0] ENV_PSID        = 2'd0;
  localparam logic [1:0] ENV_TRANSPARENT = 2'd1;
  localparam logic [1:0] ENV_BANKSWITCH  = 2'd2;
  localparam logic [1:0] ENV_REAL        = 2'd3;

  // Target codes
  localparam logic [3:0] TGT_RAM      = 4'd0;
  localparam logic [3:0] TGT_ROM      = 4'd1;
  localparam logic [3:0] TGT_BANK_REG = 4'd2;
  localparam logic [3:0] TGT_CIA1     = 4'd3;
  localparam logic [3:0] TGT_CIA2     = 4'd4;
  localparam logic [3:0] TGT_VIC      = 4'd5;
  localparam logic [3:0] TGT_FAKE_CIA = 4'd6;
  localparam logic [3:0] TGT_SID1     = 4'd7;
  localparam logic [3:0] TGT_SID2     = 4'd8;
  localparam logic [3:0] TGT_EXT_SID  = 4'd9;

  // Configuration register indexes
  localparam logic [1:0] CFG_IDX_ENV       = 2'd0;
  localparam logic [1:0] CFG_IDX_SID1_BASE = 2'd1;
  localparam logic [1:0] CFG_IDX_SID2_BASE = 2'd2;

  // Reset values and address constants
  localparam logic [7:0]  BANK_RESET      = 8'h37;
  localparam logic [1:0]  ENV_RESET       = ENV_REAL;
  localparam logic [15:0] SID1_BASE_RESET = 16'hd400;
  localparam logic [15:0] SID2_BASE_RESET = 16'h0000;
  localparam logic [15:0] BANK_REG_ADDR   = 16'h0001;
  localparam logic [15:0] BASIC_START     = 16'ha000;
  localparam logic [15:0] IO_START        = 16'hd000;
  localparam logic [4:0]  EXT_SID_FIRST   = 5'h1d;
  localparam logic [7:0]  PAGE_ZERO       = 8'h00;
  localparam logic [7:0]  PAGE_VIC        = 8'hd0;
  localparam logic [7:0]  PAGE_CIA1       = 8'hdc;
  localparam logic [7:0]  PAGE_CIA2       = 8'hdd;
  localparam logic [5:0]  SID_WINDOW      = 6'b110101;  // 0xd400..0xd7ff

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  target;
    logic [15:0] device_address;
    logic        also_first_sid;
    logic [7:0]  first_sid_address;
    logic [7:0]  bank_value;
    logic        jump_to_ram;
  } res_t;

  typedef struct packed {
    logic [1:0]  environment;
    logic [15:0] first_sid_base;
    logic [15:0] second_sid_base;
  } cfg_t;

  typedef struct packed {
    logic       we;
    logic [7:0] wdata;
  } bank_wr_t;

endpackage

`default_nettype wire

>>> sv/home_computer_bank_address_decoder.sv
// Top level: input register, decode, result register, bank and config registers.
// Depends on hcbad_pkg and hcbad_decode.
// A transaction accepted into the input register is decoded from there and loaded into
// the result register when that register is free, and is then taken from out_*.
// Throughput: one transaction per cycle unless a full result register is not taken; the
// decode is a single combinational pass between the input and result registers.
// Reset (rst_n low, synchronous): both stages empty, bank register 0x37,
// environment 3, first SID base 0xd400, second SID base 0.
`timescale 1ns / 1ps
`default_nettype none

module home_computer_bank_address_decoder import hcbad_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // req_type[1:0], address[17:2], write_data[25:18]
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // target[3:0], device_address[19:4],
                                       // also_first_sid[20], first_sid_address[28:21],
                                       // bank_value[36:29], jump_to_ram[37]
  // Configuration writes
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  logic     s1_valid_r, s1_valid_nxt;
  in_item_t s1_item_r, s1_item_nxt;
  logic     out_valid_r, out_valid_nxt;
  res_t     out_res_r, out_res_nxt;
  logic [7:0] bank_r, bank_nxt;
  cfg_t     cfg_r, cfg_nxt;

  res_t     dec_res;
  bank_wr_t dec_bank_wr;
  logic     s1_adv, in_take;

  // Handshake: the result register frees when empty or taken
  assign s1_adv    = ~out_valid_r | out_tready;
  assign in_tready = ~s1_valid_r | s1_adv;
  assign in_take   = in_tvalid & in_tready;

  hcbad_decode u_decode (
    .item    (s1_item_r),
    .cfg     (cfg_r),
    .bank    (bank_r),
    .res     (dec_res),
    .bank_wr (dec_bank_wr)
  );

  // Next-state logic for stages and bank register
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s1_item_nxt   = s1_item_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    bank_nxt      = bank_r;
    if (s1_adv) begin
      out_valid_nxt = s1_valid_r;
      out_res_nxt   = dec_res;
      if (s1_valid_r && dec_bank_wr.we) bank_nxt = dec_bank_wr.wdata;
    end
    if (in_take) begin
      s1_item_nxt.req_type   = in_tdata[1:0];
      s1_item_nxt.address    = in_tdata[17:2];
      s1_item_nxt.write_data = in_tdata[25:18];
    end
    if (in_take) s1_valid_nxt = 1'b1;
    else if (s1_adv) s1_valid_nxt = 1'b0;
  end

  // Configuration writes; indexes beyond the list are ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_ENV:       cfg_nxt.environment     = cfg_wdata[1:0];
        CFG_IDX_SID1_BASE: cfg_nxt.first_sid_base  = cfg_wdata;
        CFG_IDX_SID2_BASE: cfg_nxt.second_sid_base = cfg_wdata;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      bank_r      <= BANK_RESET;
      cfg_r       <= '{environment: ENV_RESET,
                       first_sid_base: SID1_BASE_RESET,
                       second_sid_base: SID2_BASE_RESET};
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      bank_r      <= bank_nxt;
      cfg_r       <= cfg_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    s1_item_r <= s1_item_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.jump_to_ram, out_res_r.bank_value,
                       out_res_r.first_sid_address, out_res_r.also_first_sid,
                       out_res_r.device_address, out_res_r.target};

endmodule

`default_nettype wire

>>> sv/hcbad_decode.sv
// Combinational bank and I/O decode of one bus transaction.
// Depends on hcbad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hcbad_decode import hcbad_pkg::*; (
  input  in_item_t item,
  input  cfg_t     cfg,
  input  logic [7:0] bank,
  output res_t     res,
  output bank_wr_t bank_wr
);

  logic [15:0] a;
  logic [3:0]  nib;
  logic [7:0]  hi;
  logic        is_rd, is_wr, is_jmp;
  logic        basic, io_on, kernal, real_m;
  logic        go_io, go_plain, go_rom;
  logic        sid_hit, plain_sel, jmp_ram;

  assign a      = item.address;
  assign nib    = a[15:12];
  assign hi     = a[15:8];
  assign is_rd  = (item.req_type == REQ_READ);
  assign is_wr  = (item.req_type == REQ_WRITE);
  assign is_jmp = (item.req_type == REQ_JUMP);
  assign basic  = (bank[1:0] == 2'b11);
  assign io_on  = (bank[2:0] > 3'd4);
  assign kernal = bank[1];
  assign real_m = (cfg.environment == ENV_REAL);

  // Pick the access path: I/O decode, plain RAM/bank reg, ROM, else RAM
  always_comb begin
    go_io    = 1'b0;
    go_plain = 1'b0;
    go_rom   = 1'b0;
    if (is_rd) begin
      priority if (cfg.environment == ENV_PSID) begin
        go_io = 1'b1;
      end else if (cfg.environment == ENV_TRANSPARENT) begin
        if (a < IO_START) go_plain = 1'b1;
        else if (nib == 4'hd) go_io = io_on;
      end else begin
        priority if (a < BASIC_START) go_plain = 1'b1;
        else if (nib == 4'ha || nib == 4'hb) go_rom = basic;
        else if (nib == 4'hd) go_io = io_on;
        else if (nib >= 4'he) go_rom = kernal;
        else go_rom = 1'b0;  // 0xc000 page is always RAM
      end
    end else if (is_wr) begin
      priority if (cfg.environment == ENV_PSID) go_io = 1'b1;
      else if (a < BASIC_START) go_plain = 1'b1;
      else if (nib == 4'hd) go_io = io_on;
      else go_plain = 1'b0;  // everything else writes RAM
    end
  end

  // I/O page 0 falls back to the plain decode
  assign sid_hit   = (a[15:10] == SID_WINDOW);
  assign plain_sel = go_plain | (go_io & ~sid_hit & (hi == PAGE_ZERO));

  // Jump target check
  always_comb begin
    jmp_ram = 1'b1;
    if (cfg.environment == ENV_BANKSWITCH) begin
      priority if (nib == 4'ha || nib == 4'hb) jmp_ram = ~basic;
      else if (nib == 4'hd) jmp_ram = ~io_on;
      else if (nib >= 4'he) jmp_ram = ~kernal;
      else jmp_ram = 1'b1;
    end else if (cfg.environment == ENV_TRANSPARENT) begin
      jmp_ram = ~((a >= IO_START) & kernal);
    end
  end

  // Result assembly
  always_comb begin
    res = '0;
    if (is_jmp) begin
      res.jump_to_ram = jmp_ram;
    end else if (plain_sel) begin
      res.device_address = a;
      if (a == BANK_REG_ADDR) begin
        res.target     = TGT_BANK_REG;
        res.bank_value = is_wr ? item.write_data : bank;
      end else begin
        res.target = TGT_RAM;
      end
    end else if (go_io && sid_hit) begin
      if (is_wr && a[4:0] >= EXT_SID_FIRST) begin
        res.target         = TGT_EXT_SID;
        res.device_address = {7'd0, a[8:0]};
      end else if ({hi, 8'h00} == cfg.second_sid_base) begin
        res.target         = TGT_SID2;
        res.device_address = {8'd0, a[7:0]};
        if (is_wr && cfg.second_sid_base == cfg.first_sid_base) begin
          res.also_first_sid    = 1'b1;
          res.first_sid_address = {3'd0, a[4:0]};
        end
      end else begin
        res.target         = TGT_SID1;
        res.device_address = {11'd0, a[4:0]};
      end
    end else if (go_io) begin
      priority if (real_m && hi == PAGE_CIA1) begin
        res.target         = TGT_CIA1;
        res.device_address = {12'd0, a[3:0]};
      end else if (real_m && hi == PAGE_CIA2) begin
        res.target         = TGT_CIA2;
        res.device_address = {12'd0, a[3:0]};
      end else if (real_m && hi == PAGE_VIC) begin
        res.target         = TGT_VIC;
        res.device_address = {10'd0, a[5:0]};
      end else if (!real_m && hi == PAGE_CIA1) begin
        res.target         = TGT_FAKE_CIA;
        res.device_address = {12'd0, a[3:0]};
      end else begin
        res.target         = TGT_ROM;
        res.device_address = a;
      end
    end else if (is_rd || is_wr) begin
      res.target         = go_rom ? TGT_ROM : TGT_RAM;
      res.device_address = a;
    end
  end

  // Bank register update on a write to address 1
  assign bank_wr.we    = is_wr & plain_sel & (a == BANK_REG_ADDR);
  assign bank_wr.wdata = item.write_data;

endmodule

`default_nettype wire
